FILE: hdl/group_varint_decoder_assert.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the group varint decoder modules
// ----------------------------------------------------------------------------
`ifndef GROUP_VARINT_DECODER_ASSERT_SVH
`define GROUP_VARINT_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GVD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gvd_pkg.sv
// ----------------------------------------------------------------------------
// gvd_pkg
// types and constants shared by the group varint decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gvd_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 24;
    localparam int BYTES_W = 27;
    localparam int PART_W  = 24;

    // descriptor that marks four one-byte values
    localparam logic [BYTE_W-1:0] DESC_ALL_ONE = 8'hFF;
    // last slot of a group
    localparam logic [1:0] LAST_SLOT = 2'd3;

    // one buffered input beat
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_beat;

    // one result as produced by the step logic
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [BYTES_W-1:0] bytes;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/gvd_in_reg.sv
// ----------------------------------------------------------------------------
// gvd_in_reg
// input register: captures one stream byte, frees itself when consumed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gvd_in_reg
    import gvd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [BYTE_W-1:0] i_stream_byte,
    input  wire logic              i_advance,
    output t_beat                  o_beat
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;

    assign o_in_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data <= i_stream_byte;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_data;

endmodule

`default_nettype wire

FILE: hdl/gvd_core.sv
// ----------------------------------------------------------------------------
// gvd_core
// decode state and the per-byte step: descriptor capture, byte assembly,
// value and byte counting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "group_varint_decoder_assert.svh"

module gvd_core
    import gvd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic [BYTE_W-1:0]  i_byte,
    input  wire logic [COUNT_W-1:0] i_value_count,
    output t_result                 o_res
);

    logic               r_expect_desc, n_expect_desc;
    logic [BYTE_W-1:0]  r_desc,        n_desc;
    logic [1:0]         r_slot,        n_slot;
    logic [1:0]         r_bidx,        n_bidx;
    logic [PART_W-1:0]  r_partial,     n_partial;
    logic [COUNT_W-1:0] r_vdone,       n_vdone;
    logic [BYTES_W-1:0] r_bdone,       n_bdone;

    logic [BYTE_W-1:0]  code_sh;
    logic [1:0]         code;
    logic [VALUE_W-1:0] byte_sh;
    logic [VALUE_W-1:0] val;
    logic [BYTES_W-1:0] bdone_inc;
    logic [COUNT_W-1:0] vdone_inc;

    assign code_sh   = r_desc >> {r_slot, 1'b0};
    assign code      = (r_desc == DESC_ALL_ONE) ? 2'd0 : code_sh[1:0];
    assign byte_sh   = {{(VALUE_W-BYTE_W){1'b0}}, i_byte} << {r_bidx, 3'b000};
    assign val       = {{(VALUE_W-PART_W){1'b0}}, r_partial} | byte_sh;
    assign bdone_inc = r_bdone + 1'b1;
    assign vdone_inc = r_vdone + 1'b1;

    always_comb begin
        n_expect_desc = r_expect_desc;
        n_desc        = r_desc;
        n_slot        = r_slot;
        n_bidx        = r_bidx;
        n_partial     = r_partial;
        n_vdone       = r_vdone;
        n_bdone       = r_bdone;
        o_res.valid   = 1'b0;
        o_res.value   = val;
        o_res.last    = 1'b0;
        o_res.bytes   = '0;
        if (i_step) begin
            n_bdone = bdone_inc;
            if (r_expect_desc) begin
                n_desc        = i_byte;
                n_expect_desc = 1'b0;
                n_slot        = 2'd0;
                n_bidx        = 2'd0;
                n_partial     = '0;
            end else if (r_bidx < code) begin
                n_partial = val[PART_W-1:0];
                n_bidx    = r_bidx + 1'b1;
            end else begin
                o_res.valid = 1'b1;
                n_vdone     = vdone_inc;
                if (vdone_inc == i_value_count) begin
                    // array complete: report and start over
                    o_res.last    = 1'b1;
                    o_res.bytes   = bdone_inc;
                    n_expect_desc = 1'b1;
                    n_desc        = '0;
                    n_slot        = 2'd0;
                    n_bidx        = 2'd0;
                    n_partial     = '0;
                    n_vdone       = '0;
                    n_bdone       = '0;
                end else begin
                    n_bidx    = 2'd0;
                    n_partial = '0;
                    if (r_slot == LAST_SLOT) begin
                        n_slot        = 2'd0;
                        n_expect_desc = 1'b1;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_desc <= 1'b1;
            r_desc        <= '0;
            r_slot        <= 2'd0;
            r_bidx        <= 2'd0;
            r_partial     <= '0;
            r_vdone       <= '0;
            r_bdone       <= '0;
        end else begin
            r_expect_desc <= n_expect_desc;
            r_desc        <= n_desc;
            r_slot        <= n_slot;
            r_bidx        <= n_bidx;
            r_partial     <= n_partial;
            r_vdone       <= n_vdone;
            r_bdone       <= n_bdone;
        end
    end

    // a stored byte position never passes the length code of its slot
    `GVD_ASSERT_NOW(a_bidx_range, i_clk, i_rst_n, 1'b1, r_bidx <= code, "byte index out of range")
    // a descriptor byte never yields a value
    `GVD_ASSERT_NOW(a_desc_no_result, i_clk, i_rst_n, i_step && r_expect_desc, !o_res.valid, "result on descriptor")
    // closing an array clears the counters and waits for a descriptor
    `GVD_ASSERT_NEXT(a_array_restart, i_clk, i_rst_n, o_res.valid && o_res.last, r_expect_desc && (r_bdone == '0) && (r_vdone == '0), "array did not restart")

endmodule

`default_nettype wire

FILE: hdl/group_varint_decoder.sv
// ----------------------------------------------------------------------------
// group_varint_decoder
// decodes a group varint byte stream into 32-bit values, flagging the last
// value of each array together with the stream bytes it took
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_ready   i_stream_byte
//  out       source     o_out_valid / i_out_ready o_decoded_value, o_last_value,
//                                                 o_bytes_used
//  cfg       sink       i_cfg_we (no wait)        i_cfg_data (value_count)
//
//  one byte per cycle sustained while the output is not stalled; a byte reaches
//  the output via the input register, then the step logic into the result reg
//  the step logic is one shift-or plus a 24-bit and a 27-bit increment
//  descriptors and non-final data bytes advance without producing a beat
//  reset is synchronous, active low; value_count resets to 1
//  a stalled output holds the pipe; the input register frees as soon as the
//  result register can take the next step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "group_varint_decoder_assert.svh"

module group_varint_decoder
    import gvd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input byte stream
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [BYTE_W-1:0]  i_stream_byte,
    // decoded values
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [VALUE_W-1:0]      o_decoded_value,
    output logic                    o_last_value,
    output logic [BYTES_W-1:0]      o_bytes_used,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_data
);

    t_beat              beat;
    t_result            res;
    logic               step;
    logic               out_free;

    logic [COUNT_W-1:0] r_value_count;

    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_last;
    logic [BYTES_W-1:0] r_out_bytes;

    // values per array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_count <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            r_value_count <= i_cfg_data;
        end
    end

    // the result register can take a new step when empty or being drained
    assign out_free = !r_out_valid || i_out_ready;
    assign step     = beat.valid && out_free;

    gvd_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_stream_byte (i_stream_byte),
        .i_advance     (step),
        .o_beat        (beat)
    );

    gvd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (beat.data),
        .i_value_count (r_value_count),
        .o_res         (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res.valid) begin
            r_out_value <= res.value;
            r_out_last  <= res.last;
            r_out_bytes <= res.bytes;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_decoded_value = r_out_value;
    assign o_last_value    = r_out_last;
    assign o_bytes_used    = r_out_bytes;

    // byte count is only reported on the last value of an array
    `GVD_ASSERT_NOW(a_bytes_only_last, i_clk, i_rst_n, r_out_valid && !r_out_last, r_out_bytes == '0, "byte count on non-last beat")
    // input only backs up behind a stalled output
    `GVD_ASSERT_NOW(a_ready_cause, i_clk, i_rst_n, !o_in_ready, r_out_valid && !i_out_ready, "input stalled without output stall")
    // a stalled output beat stays put
    `GVD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid && $stable(r_out_value), "output beat changed while stalled")

endmodule

`default_nettype wire

FILE: bench/tb_group_varint_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_group_varint_decoder
// self-checking bench for the group varint decoder: drives biased byte
// streams under random idling on both sides, predicts every decoded value,
// the end-of-array flag and byte count, and checks each output beat in order
// ----------------------------------------------------------------------------

module tb_group_varint_decoder;
    import gvd_pkg::*;

    localparam int STALL_LIMIT  = 2000; // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 4;    // two-stage pipe plus margin
    localparam int PHASE_BYTES  = 62;
    localparam int NUM_PHASES   = 18;
    localparam int HOLD_CYCLES  = 300;

    // one decoded value as seen on the output channel
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [BYTES_W-1:0] bytes;
    } value_beat_t;

    // decoder state tracking plus in-order value checking
    class value_scoreboard;
        logic [COUNT_W-1:0] count_reg;
        bit                 want_desc;
        logic [BYTE_W-1:0]  desc;
        logic [1:0]         slot;
        logic [1:0]         byte_pos;
        logic [PART_W-1:0]  partial;
        logic [COUNT_W-1:0] values_done;
        logic [BYTES_W-1:0] bytes_done;
        value_beat_t        expected_q[$];
        int                 mismatches;
        int                 n_bytes;
        int                 n_checked;
        int                 n_arrays;

        function new();
            count_reg  = 1;
            mismatches = 0;
            n_bytes    = 0;
            n_checked  = 0;
            n_arrays   = 0;
            restart_array();
        endfunction

        function void restart_array();
            want_desc   = 1'b1;
            desc        = '0;
            slot        = '0;
            byte_pos    = '0;
            partial     = '0;
            values_done = '0;
            bytes_done  = '0;
        endfunction

        function void set_count(input logic [COUNT_W-1:0] v);
            count_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // advance the decoder state by one accepted stream byte
        function void note_byte(input logic [BYTE_W-1:0] b);
            logic [1:0]         code;
            logic [VALUE_W-1:0] word;
            value_beat_t        beat;
            n_bytes++;
            bytes_done = bytes_done + 1'b1;
            if (want_desc) begin
                desc      = b;
                want_desc = 1'b0;
                slot      = '0;
                byte_pos  = '0;
                partial   = '0;
                return;
            end
            code = (desc == DESC_ALL_ONE) ? 2'd0 : desc[2*slot +: 2];
            word = VALUE_W'(partial) | (VALUE_W'(b) << (8 * byte_pos));
            if (byte_pos < code) begin
                partial  = word[PART_W-1:0];
                byte_pos = byte_pos + 1'b1;
                return;
            end
            values_done = values_done + 1'b1;
            beat.value  = word;
            if (values_done == count_reg) begin
                beat.last  = 1'b1;
                beat.bytes = bytes_done;
                expected_q.push_back(beat);
                n_arrays++;
                restart_array();
                return;
            end
            beat.last  = 1'b0;
            beat.bytes = '0;
            expected_q.push_back(beat);
            byte_pos = '0;
            partial  = '0;
            if (slot == LAST_SLOT) begin
                slot      = '0;
                want_desc = 1'b1;
            end else begin
                slot = slot + 1'b1;
            end
        endfunction

        function void flag(input string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_value(input logic [VALUE_W-1:0] value,
                                  input logic last,
                                  input logic [BYTES_W-1:0] bytes);
            value_beat_t beat;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected beat: value %h last %b bytes %0d",
                               value, last, bytes));
                return;
            end
            beat = expected_q.pop_front();
            n_checked++;
            if (beat.value !== value || beat.last !== last || beat.bytes !== bytes)
                flag($sformatf("mismatch: expected value %h last %b bytes %0d, got value %h last %b bytes %0d",
                               beat.value, beat.last, beat.bytes, value, last, bytes));
        endfunction
    endclass

    // dut signals, all inputs known from time zero
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic [BYTE_W-1:0]  i_stream_byte = '0;
    logic               i_out_ready   = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [COUNT_W-1:0] i_cfg_data    = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [VALUE_W-1:0] o_decoded_value;
    logic               o_last_value;
    logic [BYTES_W-1:0] o_bytes_used;

    value_scoreboard sb;

    // idling controls shared between the stimulus and the receiver
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int rx_hold    = 0;
    int n_settings = 0;

    group_varint_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_stream_byte   (i_stream_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_decoded_value (o_decoded_value),
        .o_last_value    (o_last_value),
        .o_bytes_used    (o_bytes_used),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // offer one byte after a random gap; valid stays high across back-to-back beats
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stream_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b);
    endtask

    task automatic send_list(input logic [BYTE_W-1:0] list[$]);
        foreach (list[i])
            send_byte(list[i]);
        i_in_valid <= 1'b0;
    endtask

    // every byte value is legal, so the stream is always well formed;
    // descriptors lean toward the all-one marker and uniform length codes,
    // data bytes toward the extremes
    function automatic logic [BYTE_W-1:0] next_stream_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (sb.want_desc) begin
            case (pick)
                0, 1:    return DESC_ALL_ONE;
                2:       return 8'h00;
                3:       return 8'hAA;
                4:       return 8'h55;
                default: return BYTE_W'($urandom);
            endcase
        end
        case (pick)
            0, 1, 2: return 8'h00;
            3, 4, 5: return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_byte(next_stream_byte());
        i_in_valid <= 1'b0;
    endtask

    // all values out, then let any trailing non-value bytes clear the pipe
    task automatic wait_idle();
        int settled;
        while (sb.pending() != 0) @(posedge i_clk);
        settled = 0;
        while (settled < DRAIN_CYCLES) begin
            @(posedge i_clk);
            if (i_out_ready)
                settled++;
        end
    endtask

    // value_count only changes with the pipe empty
    task automatic write_count(input logic [COUNT_W-1:0] v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_count(v);
        n_settings++;
    endtask

    // receiver: random stall per beat, or one long hold-off on request
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 14) : 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_value(o_decoded_value, o_last_value, o_bytes_used);
        end
    end

    // watchdog on progress: any beat on either channel restarts the count
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("[group_varint_decoder] ERROR");
        $finish;
    end

    initial begin
        logic [BYTE_W-1:0]  directed_q[$];
        logic [COUNT_W-1:0] next_count;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count of one: zero value, then all-one marker with 0xff data
        directed_q = {8'h00, 8'h00, DESC_ALL_ONE, 8'hFF};
        send_list(directed_q);

        // one value of each length, the last one all ones
        write_count(24'd4);
        directed_q = {8'hE4, 8'hFF, 8'h34, 8'h12, 8'h56, 8'h34, 8'h12,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_list(directed_q);

        // array ends inside a group, the abandoned slot's byte becomes a descriptor
        write_count(24'd3);
        directed_q = {DESC_ALL_ONE, 8'h00, 8'h80, 8'h7F,
                      8'h1B, 8'h78, 8'h56, 8'h34, 8'h12};
        send_list(directed_q);

        // random phases, each with its own count and idling mix
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                3:       next_count = '0;                       // counter has to wrap
                4:       next_count = '1;                       // largest count
                5:       next_count = sb.values_done + 24'd2;   // close the long array
                7:       next_count = 24'd200;
                8:       next_count = sb.values_done >> 1;      // lowered below progress
                9:       next_count = sb.values_done + 24'd1 + COUNT_W'($urandom_range(0, 5));
                default: next_count = ($urandom_range(0, 3) == 0) ?
                                      COUNT_W'($urandom_range(13, 60)) :
                                      COUNT_W'($urandom_range(1, 12));
            endcase
            tx_idle_on = (ph % 3 != 0);
            rx_idle_on = (ph % 4 != 1);
            // back-pressure phase: sender at full rate against a long hold-off
            if (ph == 6) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
                rx_hold    = HOLD_CYCLES;
            end
            write_count(next_count);
            send_random(PHASE_BYTES);
        end

        wait_idle();
        $display("run covered %0d stream bytes, %0d values checked, %0d arrays closed",
                 sb.n_bytes, sb.n_checked, sb.n_arrays);
        $display("value_count took %0d settings incl. zero, max, lowered and raised mid-array",
                 n_settings);
        if (sb.mismatches == 0) begin
            $display("[group_varint_decoder] OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("[group_varint_decoder] ERROR");
        end
        $finish;
    end

endmodule
